### sv/ptb_pkg.sv
// shared types, sizes and codes of the palindromic tree builder
`timescale 1ns / 1ps

package ptb_pkg;

  localparam int MAX_LETTERS = 1024;
  localparam int ALPHABET    = 26;
  localparam int NODE_COUNT  = MAX_LETTERS + 2;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int LEN_W       = $clog2(MAX_LETTERS + 1);
  localparam int POS_W       = LEN_W;
  localparam int LETTER_AW   = (MAX_LETTERS > 2) ? $clog2(MAX_LETTERS) : 1;
  localparam int SYM_W       = 5;
  localparam int OCC_W       = 11;
  localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int DIFF_W      = LEN_W + 1;

  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [SYM_W-1:0]     sym_t;
  typedef logic [OCC_W-1:0]     occ_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [LETTER_AW-1:0] laddr_t;
  typedef logic [CHILD_AW-1:0]  caddr_t;

  localparam node_t ROOT_ZERO = node_t'(0);
  localparam node_t ROOT_ONE  = node_t'(1);
  localparam node_t FIRST_NODE = node_t'(2);

  // one entry of the node store
  typedef struct packed {
    len_t  len;
    node_t link;
    occ_t  occ;
    node_t parent;
    sym_t  sym;
  } node_rec_t;

  // answer of the extension check unit
  typedef struct packed {
    logic   root;
    logic   before_start;
    laddr_t mirror;
  } ext_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VRD,
    S_VCHK,
    S_LCHK,
    S_CCHK,
    S_XCHK,
    S_MAKE,
    S_DONE
  } state_e;

endpackage

### sv/ptb_ext_unit.sv
// extension check unit: mirror position of a palindrome and its range test
`timescale 1ns / 1ps

module ptb_ext_unit (
  input  ptb_pkg::laddr_t   at_i,
  input  ptb_pkg::len_t     len_i,
  input  logic              neg_i,
  output ptb_pkg::ext_res_t res_o
);
  import ptb_pkg::*;

  logic [DIFF_W-1:0] diff;

  // mirror = at - len - 1, negative means before the first letter
  assign diff = DIFF_W'(at_i) - DIFF_W'(len_i) - DIFF_W'(1);

  assign res_o.root         = neg_i;
  assign res_o.before_start = diff[DIFF_W-1];
  assign res_o.mirror       = diff[LETTER_AW-1:0];

endmodule

### sv/palindromic_tree_builder_top.sv
// top level of the palindromic tree builder: sequencer, stores and output register
`timescale 1ns / 1ps

// Builds a palindromic tree (eertree) online, one letter per input word, and
// returns one result word per letter: the node of the longest palindromic
// suffix, its length, whether the letter created it, and its end count after
// the increment. A letter outside the alphabet gives an all-zero result and
// changes nothing; once the letter store is full, letters are ignored and the
// result carries only the overflow flag. The block takes one letter at a time:
// in_stall_o is high from acceptance until the result is in the output
// register. An ignored letter goes straight to the result. A stored letter is
// taken, then each suffix link tried is read from the node store and checked
// against the length -1 root and the string start, a stored letter compared
// when neither settles it; then the child edge is looked up and the result
// staged; when a node is made, a second walk finds its link unless its length
// is one, and then it is written. Every step of the walk goes through the
// single read port of the node store. A full output register that is not
// taken holds the next result back. No clearing pass is needed after reset:
// a child edge counts only if the node it names is in use and records that
// parent and letter, and node entries are written when their node is made.
module palindromic_tree_builder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  // letter input
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ptb_pkg::sym_t  letter_i,
  // result output
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ptb_pkg::node_t suffix_node_o,
  output ptb_pkg::len_t  suffix_length_o,
  output logic           created_o,
  output ptb_pkg::occ_t  end_count_o,
  output logic           overflow_o
);
  import ptb_pkg::*;

  function automatic caddr_t child_addr(node_t v, sym_t c);
    return CHILD_AW'(v) * CHILD_AW'(ALPHABET) + CHILD_AW'(c);
  endfunction

  // sequencer
  state_e state_q, state_d;

  // tree bookkeeping
  pos_t  pos_q, pos_d;
  node_t total_q, total_d;
  node_t cur_q, cur_d;
  occ_t  occ0_q, occ0_d;

  // per-letter working registers
  sym_t   c_q, c_d;
  laddr_t at_q, at_d;
  logic   phase_q, phase_d;       // low: first walk, high: walk for the new link
  node_t  v_q, v_d;               // node under test in the walk
  len_t   vlen_q, vlen_d;
  logic   vneg_q, vneg_d;
  node_t  vlink_q, vlink_d;
  node_t  pv_q, pv_d;             // parent of a node about to be made
  len_t   pvlen_q, pvlen_d;
  logic   pvneg_q, pvneg_d;
  node_t  x_q, x_d;               // child edge read back from the store
  node_t  link_q, link_d;

  // staged result
  node_t res_node_q, res_node_d;
  len_t  res_len_q, res_len_d;
  logic  res_made_q, res_made_d;
  occ_t  res_occ_q, res_occ_d;
  logic  res_ovf_q, res_ovf_d;

  // output register
  logic  out_valid_q, out_valid_d;
  node_t out_node_q;
  len_t  out_len_q;
  logic  out_made_q;
  occ_t  out_occ_q;
  logic  out_ovf_q;

  // stores
  sym_t      letter_mem [MAX_LETTERS];
  node_t     child_mem  [CHILD_DEPTH];
  node_rec_t node_mem   [NODE_COUNT];

  sym_t      let_rdata_q;
  node_t     child_rdata_q;
  node_rec_t node_rdata_q;

  laddr_t    let_raddr;
  caddr_t    child_raddr;
  node_t     node_raddr;
  logic      let_we;
  logic      child_we;
  caddr_t    child_waddr;
  node_t     child_wdata;
  logic      node_we;
  node_t     node_waddr;
  node_rec_t node_wdata;

  // handshake
  logic accept;
  logic out_free;
  logic bad_letter;
  logic store_full;

  // walk step signals
  len_t     rec_len;
  logic     rec_neg;
  node_t    rec_link;
  ext_res_t ext;
  logic     x_valid;
  logic     room;
  node_t    fresh;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign bad_letter = (letter_i > SYM_W'(ALPHABET - 1));
  assign store_full = (pos_q >= POS_W'(MAX_LETTERS));

  // the two roots live in constants, all other nodes in the store
  always_comb begin
    if (v_q == ROOT_ONE) begin
      rec_len  = '0;
      rec_neg  = 1'b1;
      rec_link = ROOT_ONE;
    end else if (v_q == ROOT_ZERO) begin
      rec_len  = '0;
      rec_neg  = 1'b0;
      rec_link = ROOT_ONE;
    end else begin
      rec_len  = node_rdata_q.len;
      rec_neg  = 1'b0;
      rec_link = node_rdata_q.link;
    end
  end

  ptb_ext_unit u_ext (
    .at_i  (at_q),
    .len_i (rec_len),
    .neg_i (rec_neg),
    .res_o (ext)
  );

  // an edge counts only if it names a node in use that records this parent and letter
  assign x_valid = (x_q >= FIRST_NODE) && (x_q <= total_q) &&
                   (node_rdata_q.parent == v_q) && (node_rdata_q.sym == c_q);
  assign room    = (int'(total_q) + 1) < NODE_COUNT;
  assign fresh   = total_q + node_t'(1);

  // read addresses
  assign let_raddr   = ext.mirror;
  assign child_raddr = child_addr(v_q, c_q);
  assign node_raddr  = (state_q == S_CCHK) ? child_rdata_q : v_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (bad_letter || store_full) begin
            state_d = S_DONE;
          end else begin
            state_d = S_VRD;
          end
        end
      end
      S_VRD: begin
        state_d = S_VCHK;
      end
      S_VCHK: begin
        if (ext.root) begin
          state_d = S_CCHK;
        end else if (ext.before_start) begin
          state_d = S_VRD;
        end else begin
          state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        if (let_rdata_q == c_q) begin
          state_d = S_CCHK;
        end else begin
          state_d = S_VRD;
        end
      end
      S_CCHK: begin
        state_d = S_XCHK;
      end
      S_XCHK: begin
        if (phase_q) begin
          state_d = S_MAKE;
        end else if (x_valid) begin
          state_d = S_DONE;
        end else if (room) begin
          state_d = vneg_q ? S_MAKE : S_VRD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MAKE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    pos_d      = pos_q;
    total_d    = total_q;
    cur_d      = cur_q;
    occ0_d     = occ0_q;
    c_d        = c_q;
    at_d       = at_q;
    phase_d    = phase_q;
    v_d        = v_q;
    vlen_d     = vlen_q;
    vneg_d     = vneg_q;
    vlink_d    = vlink_q;
    pv_d       = pv_q;
    pvlen_d    = pvlen_q;
    pvneg_d    = pvneg_q;
    x_d        = x_q;
    link_d     = link_q;
    res_node_d = res_node_q;
    res_len_d  = res_len_q;
    res_made_d = res_made_q;
    res_occ_d  = res_occ_q;
    res_ovf_d  = res_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;

    let_we      = 1'b0;
    child_we    = 1'b0;
    child_waddr = child_addr(pv_q, c_q);
    child_wdata = fresh;
    node_we     = 1'b0;
    node_waddr  = x_q;
    node_wdata  = node_rdata_q;

    case (state_q)
      S_IDLE: begin
        res_node_d = ROOT_ZERO;
        res_len_d  = '0;
        res_made_d = 1'b0;
        res_occ_d  = '0;
        res_ovf_d  = 1'b0;
        if (accept) begin
          c_d     = letter_i;
          at_d    = LETTER_AW'(pos_q);
          v_d     = cur_q;
          phase_d = 1'b0;
          if (!bad_letter && store_full) begin
            res_ovf_d = 1'b1;
          end else if (!bad_letter) begin
            let_we = 1'b1;
            pos_d  = pos_q + pos_t'(1);
          end
        end
      end
      S_VCHK: begin
        vlen_d  = rec_len;
        vneg_d  = rec_neg;
        vlink_d = rec_link;
        if (!ext.root && ext.before_start) begin
          v_d = rec_link;
        end
      end
      S_LCHK: begin
        if (let_rdata_q != c_q) begin
          v_d = vlink_q;
        end
      end
      S_CCHK: begin
        x_d = child_rdata_q;
      end
      S_XCHK: begin
        if (phase_q) begin
          if (x_valid) begin
            link_d = x_q;
          end else begin
            link_d = ROOT_ZERO;
          end
        end else begin
          pv_d    = v_q;
          pvlen_d = vlen_q;
          pvneg_d = vneg_q;
          if (x_valid) begin
            // existing node: bump its count in place
            node_we        = 1'b1;
            node_waddr     = x_q;
            node_wdata     = node_rdata_q;
            node_wdata.occ = node_rdata_q.occ + occ_t'(1);
            cur_d          = x_q;
            res_node_d     = x_q;
            res_len_d      = node_rdata_q.len;
            res_occ_d      = node_rdata_q.occ + occ_t'(1);
          end else if (room) begin
            phase_d = 1'b1;
            link_d  = ROOT_ZERO;
            v_d     = vlink_q;
          end else begin
            // no node left: the suffix falls to the empty root
            occ0_d     = occ0_q + occ_t'(1);
            cur_d      = ROOT_ZERO;
            res_node_d = ROOT_ZERO;
            res_len_d  = '0;
            res_occ_d  = occ0_q + occ_t'(1);
          end
        end
      end
      S_MAKE: begin
        node_we           = 1'b1;
        node_waddr        = fresh;
        node_wdata.len    = pvneg_q ? len_t'(1) : pvlen_q + len_t'(2);
        node_wdata.link   = link_q;
        node_wdata.occ    = occ_t'(1);
        node_wdata.parent = pv_q;
        node_wdata.sym    = c_q;
        child_we          = 1'b1;
        child_waddr       = child_addr(pv_q, c_q);
        child_wdata       = fresh;
        total_d           = fresh;
        cur_d             = fresh;
        res_node_d        = fresh;
        res_len_d         = node_wdata.len;
        res_made_d        = 1'b1;
        res_occ_d         = occ_t'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      total_q     <= ROOT_ONE;
      cur_q       <= ROOT_ZERO;
      occ0_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      total_q     <= total_d;
      cur_q       <= cur_d;
      occ0_q      <= occ0_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    at_q       <= at_d;
    v_q        <= v_d;
    vlen_q     <= vlen_d;
    vneg_q     <= vneg_d;
    vlink_q    <= vlink_d;
    pv_q       <= pv_d;
    pvlen_q    <= pvlen_d;
    pvneg_q    <= pvneg_d;
    x_q        <= x_d;
    link_q     <= link_d;
    res_node_q <= res_node_d;
    res_len_q  <= res_len_d;
    res_made_q <= res_made_d;
    res_occ_q  <= res_occ_d;
    res_ovf_q  <= res_ovf_d;
    if (state_q == S_DONE && out_free) begin
      out_node_q <= res_node_q;
      out_len_q  <= res_len_q;
      out_made_q <= res_made_q;
      out_occ_q  <= res_occ_q;
      out_ovf_q  <= res_ovf_q;
    end
  end

  // letter store
  always_ff @(posedge clk_i) begin
    if (let_we) begin
      letter_mem[LETTER_AW'(pos_q)] <= letter_i;
    end
    let_rdata_q <= letter_mem[let_raddr];
  end

  // child edge store
  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    child_rdata_q <= child_mem[child_raddr];
  end

  // node store
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata_q <= node_mem[node_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign suffix_node_o   = out_node_q;
  assign suffix_length_o = out_len_q;
  assign created_o       = out_made_q;
  assign end_count_o     = out_occ_q;
  assign overflow_o      = out_ovf_q;

endmodule

### sv/ptb_checker.sv
// port-level checks of the palindromic tree builder and their bind
`timescale 1ns / 1ps

module ptb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ptb_pkg::node_t suffix_node_o,
  input ptb_pkg::len_t  suffix_length_o,
  input logic           created_o,
  input ptb_pkg::occ_t  end_count_o,
  input logic           overflow_o
);
  import ptb_pkg::*;

  // one letter at a time: busy right after an accepted word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(suffix_node_o) &&
                                     $stable(end_count_o)))
    else $error("stalled result changed");

  // an ignored letter carries nothing but the flag
  a_overflow_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (suffix_node_o == ROOT_ZERO &&
                                     suffix_length_o == '0 && !created_o &&
                                     end_count_o == '0))
    else $error("overflow result with payload");

  // a fresh node has been seen once and is never a root
  a_created_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && created_o) |-> (end_count_o == occ_t'(1) &&
                                    suffix_node_o >= FIRST_NODE &&
                                    suffix_length_o != '0))
    else $error("new node result inconsistent");

  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && suffix_node_o == ROOT_ZERO) |-> (suffix_length_o == '0))
    else $error("empty root reported with a length");

endmodule

bind palindromic_tree_builder_top ptb_checker u_ptb_checker (.*);
